// ===== rtl/core/llis_pkg.sv =====
// Shared widths, defaults and controller state type for the linked list insertion sorter.
package llis_pkg;

    localparam int KEY_W         = 32;
    localparam int IDX_W         = 6;
    localparam int CNT_W         = 7;
    localparam int SLOT_COUNT    = 64;
    localparam int MAX_ITEMS_DEF = 64;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_FIX  = 5'b00100,
        S_ERD  = 5'b01000,
        S_EWR  = 5'b10000
    } t_state;

endpackage

// ===== rtl/core/llis_if.sv =====
// Valid/ready channel interfaces for input words and sorted result words.
interface llis_in_if
    import llis_pkg::*;
();
    logic valid;
    logic ready;
    t_key value;
    logic final_item;

    modport source (output valid, output value, output final_item, input ready);
    modport sink   (input valid, input value, input final_item, output ready);
endinterface

interface llis_out_if
    import llis_pkg::*;
();
    logic valid;
    logic ready;
    t_key sorted_value;
    t_idx arrival_index;
    logic last_result;
    logic overflow;

    modport source (output valid, output sorted_value, output arrival_index,
                    output last_result, output overflow, input ready);
    modport sink   (input valid, input sorted_value, input arrival_index,
                    input last_result, input overflow, output ready);
endinterface

// ===== rtl/core/linked_list_insertion_sorter_core.sv =====
// Sorter core: keys in three link memories, backward scan insert, ordered drain on the final word.
//
// Each input word is stored in the slot given by its arrival position and linked into an
// ascending doubly linked list held in key, forward and backward link memories (one
// synchronous read port each, registered read data). A word that is the first of a set or
// that finds the store full is handled without a walk. Any other word walks back from the
// tail, visiting 1 to MAX_ITEMS-1 entries and reading one entry per cycle, and is linked in
// as the new head or after the first entry whose key is not larger. Words beyond MAX_ITEMS
// are dropped and flag overflow on every result of that set. After a word marked final, the
// whole list is drained head to tail, each result word passing through S_ERD and S_EWR, then
// the store is empty again; no input word is taken during the walk or the drain. The result
// register lets a word be accepted while the previous result still waits downstream.
module linked_list_insertion_sorter_core
    import llis_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    llis_in_if.sink           i_in,
    llis_out_if.source        o_out
);

    t_key key_mem [SLOT_COUNT];
    t_idx fwd_mem [SLOT_COUNT];
    t_idx bwd_mem [SLOT_COUNT];

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    t_idx   r_head, n_head;
    t_idx   r_tail, n_tail;
    t_idx   r_ptr, n_ptr;
    t_idx   r_nx, n_nx;
    t_idx   r_k, n_k;
    logic   r_drop, n_drop;
    t_key   r_val, n_val;
    logic   r_fin, n_fin;

    t_key   r_key_rd;
    t_idx   r_fwd_rd;
    t_idx   r_bwd_rd;

    logic   r_out_valid;
    t_key   r_out_value;
    t_idx   r_out_index;
    logic   r_out_last;
    logic   r_out_ovf;

    t_idx   slot;
    t_idx   rd_addr;
    logic   in_ready;
    logic   in_fire;
    logic   load_out;
    logic   last_word;
    logic   key_we, fwd_we, bwd_we;
    t_idx   key_wa, fwd_wa, bwd_wa;
    t_key   key_wd;
    t_idx   fwd_wd, bwd_wd;

    assign slot      = r_count[IDX_W-1:0];
    assign in_fire   = i_in.valid && in_ready;
    assign last_word = ({1'b0, r_k} + t_cnt'(1)) == r_count;

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.sorted_value  = r_out_value;
    assign o_out.arrival_index = r_out_index;
    assign o_out.last_result   = r_out_last;
    assign o_out.overflow      = r_out_ovf;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_head   = r_head;
        n_tail   = r_tail;
        n_ptr    = r_ptr;
        n_nx     = r_nx;
        n_k      = r_k;
        n_drop   = r_drop;
        n_val    = r_val;
        n_fin    = r_fin;
        in_ready = 1'b0;
        load_out = 1'b0;
        rd_addr  = r_ptr;
        key_we   = 1'b0;
        key_wa   = slot;
        key_wd   = r_val;
        fwd_we   = 1'b0;
        fwd_wa   = slot;
        fwd_wd   = '0;
        bwd_we   = 1'b0;
        bwd_wa   = slot;
        bwd_wd   = '0;
        unique case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                rd_addr  = r_tail;
                if (in_fire) begin
                    n_val = i_in.value;
                    n_fin = i_in.final_item;
                    n_ptr = r_tail;
                    n_k   = '0;
                    if (r_count < t_cnt'(MAX_ITEMS)) begin
                        key_we = 1'b1;
                        key_wd = i_in.value;
                        if (r_count == '0) begin
                            fwd_we  = 1'b1;
                            bwd_we  = 1'b1;
                            n_head  = slot;
                            n_tail  = slot;
                            n_ptr   = slot;
                            n_count = t_cnt'(1);
                            n_state = i_in.final_item ? S_ERD : S_IDLE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_drop  = 1'b1;
                        n_ptr   = r_head;
                        n_state = i_in.final_item ? S_ERD : S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                if (r_key_rd <= r_val) begin
                    // link after r_ptr; finish the successor side next cycle
                    fwd_we  = 1'b1;
                    fwd_wa  = r_ptr;
                    fwd_wd  = slot;
                    bwd_we  = 1'b1;
                    bwd_wd  = r_ptr;
                    n_nx    = r_fwd_rd;
                    n_state = S_FIX;
                end else if (r_ptr == r_head) begin
                    // smaller than everything: new head
                    fwd_we  = 1'b1;
                    fwd_wd  = r_head;
                    bwd_we  = 1'b1;
                    bwd_wa  = r_head;
                    bwd_wd  = slot;
                    n_head  = slot;
                    n_count = r_count + t_cnt'(1);
                    n_ptr   = slot;
                    n_state = r_fin ? S_ERD : S_IDLE;
                end else begin
                    rd_addr = r_bwd_rd;
                    n_ptr   = r_bwd_rd;
                end
            end
            S_FIX: begin
                fwd_we = 1'b1;
                fwd_wd = r_nx;
                if (r_ptr == r_tail) begin
                    n_tail = slot;
                end else begin
                    bwd_we = 1'b1;
                    bwd_wa = r_nx;
                    bwd_wd = slot;
                end
                n_count = r_count + t_cnt'(1);
                n_ptr   = r_head;
                n_state = r_fin ? S_ERD : S_IDLE;
            end
            S_ERD: begin
                rd_addr = r_ptr;
                if (!r_out_valid || o_out.ready) begin
                    n_state = S_EWR;
                end
            end
            S_EWR: begin
                load_out = 1'b1;
                n_ptr    = r_fwd_rd;
                n_k      = r_k + t_idx'(1);
                if (last_word) begin
                    n_count = '0;
                    n_drop  = 1'b0;
                    n_head  = '0;
                    n_tail  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_ERD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[key_wa] <= key_wd;
        end
        r_key_rd <= key_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (fwd_we) begin
            fwd_mem[fwd_wa] <= fwd_wd;
        end
        r_fwd_rd <= fwd_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (bwd_we) begin
            bwd_mem[bwd_wa] <= bwd_wd;
        end
        r_bwd_rd <= bwd_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_ptr       <= '0;
            r_k         <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_ptr   <= n_ptr;
            r_k     <= n_k;
            r_drop  <= n_drop;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_fin <= n_fin;
        r_nx  <= n_nx;
        if (load_out) begin
            r_out_value <= r_key_rd;
            r_out_index <= r_ptr;
            r_out_last  <= last_word;
            r_out_ovf   <= r_drop;
        end
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(MAX_ITEMS))
        else $error("stored count above capacity");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state not one-hot");

    a_drain_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EWR) |-> !r_out_valid)
        else $error("result register busy when drain word loads");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EWR && last_word) |=> (r_count == '0 && !r_drop))
        else $error("store not emptied after last result");

endmodule

// ===== dv/linked_list_insertion_sorter_core_tb.sv =====
// Testbench for the linked list insertion sorter core: directed table, random sets, predictor.
`timescale 1ns / 1ps

module linked_list_insertion_sorter_core_tb;
    import llis_pkg::*;

    localparam int SET_CAP       = MAX_ITEMS_DEF;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 150;
    localparam int N_DIRECTED    = 21;
    localparam int KEYS_RANDOM   = 0;
    localparam int KEYS_NARROW   = 1;
    localparam int KEYS_EXTREME  = 2;

    typedef struct packed {
        t_key sorted_value;
        t_idx arrival_index;
        logic last_result;
        logic overflow;
    } t_sorted_word;

    typedef struct packed {
        t_key key;
        t_idx slot;
    } t_entry;

    typedef struct packed {
        t_key         key;
        logic         fin;
        logic         typed;
        t_sorted_word res;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    llis_in_if  in_if ();
    llis_out_if out_if ();

    linked_list_insertion_sorter_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    // ordered list of the current set, oldest first among equal keys
    t_entry       sorted_set [$];
    logic         set_dropped;
    t_sorted_word expected_q [$];
    int           err_cnt;
    int           words_sent;
    logic         idle_on;
    int           stall_left;
    int           quiet_cycles;

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 6'd0, 1'b1, 1'b0}},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 6'd0, 1'b1, 1'b0}},
        '{32'd100,       1'b0, 1'b0, '0},
        '{32'd100,       1'b0, 1'b0, '0},
        '{32'd50,        1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b0, 1'b0, '0},
        '{32'd100,       1'b0, 1'b0, '0},
        '{32'd75,        1'b1, 1'b0, '0},
        '{32'd7,         1'b0, 1'b0, '0},
        '{32'd7,         1'b0, 1'b0, '0},
        '{32'd7,         1'b1, 1'b0, '0},
        '{32'd5,         1'b0, 1'b0, '0},
        '{32'd4,         1'b0, 1'b0, '0},
        '{32'd3,         1'b0, 1'b0, '0},
        '{32'd2,         1'b1, 1'b0, '0},
        '{32'd1,         1'b0, 1'b0, '0},
        '{32'd2,         1'b0, 1'b0, '0},
        '{32'd3,         1'b1, 1'b0, '0},
        '{32'hAAAA_AAAA, 1'b0, 1'b0, '0},
        '{32'h5555_5555, 1'b1, 1'b0, '0}
    };

    function automatic void sort_in_word(input t_key key, input logic fin,
                                         ref t_sorted_word batch [$]);
        int           pos;
        t_sorted_word r;
        if (sorted_set.size() < SET_CAP) begin
            pos = sorted_set.size();
            while (pos > 0 && sorted_set[pos-1].key > key) pos--;
            sorted_set.insert(pos, '{key: key, slot: t_idx'(sorted_set.size())});
        end else begin
            set_dropped = 1'b1;
        end
        if (fin) begin
            foreach (sorted_set[k]) begin
                r.sorted_value  = sorted_set[k].key;
                r.arrival_index = sorted_set[k].slot;
                r.last_result   = (k == sorted_set.size() - 1);
                r.overflow      = set_dropped;
                batch.push_back(r);
            end
            sorted_set.delete();
            set_dropped = 1'b0;
        end
    endfunction

    function automatic t_key pick_key(input int mode);
        case (mode)
            KEYS_NARROW: return t_key'($urandom_range(0, 15));
            KEYS_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return 32'h8000_0000;
                    default: return t_key'($urandom());
                endcase
            end
            default: return t_key'($urandom());
        endcase
    endfunction

    task automatic send_word(input t_key key, input logic fin, input logic typed,
                             input t_sorted_word typed_res);
        t_sorted_word batch [$];
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.value      <= key;
        in_if.final_item <= fin;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sort_in_word(key, fin, batch);
        if (typed) expected_q.push_back(typed_res);
        else expected_q = {expected_q, batch};
        words_sent++;
    endtask

    task automatic send_set(input int size, input int mode);
        for (int k = 0; k < size; k++) send_word(pick_key(mode), k == size - 1, 1'b0, '0);
    endtask

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %h, got %h", name, exp_val, act_val);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_on) begin
            out_if.ready <= 1'b1;
            stall_left   <= 0;
        end else if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 3);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_sorted_word exp_word;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: value %h index %0d",
                       out_if.sorted_value, out_if.arrival_index);
                err_cnt++;
            end else begin
                exp_word = expected_q.pop_front();
                check_field("sorted_value", exp_word.sorted_value, out_if.sorted_value);
                check_field("arrival_index", 32'(exp_word.arrival_index),
                            32'(out_if.arrival_index));
                check_field("last_result", 32'(exp_word.last_result),
                            32'(out_if.last_result));
                check_field("overflow", 32'(exp_word.overflow), 32'(out_if.overflow));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        err_cnt     = 0;
        words_sent  = 0;
        idle_on     = 1'b1;
        set_dropped = 1'b0;
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.value      <= '0;
        in_if.final_item <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            send_word(directed_rows[r].key, directed_rows[r].fin,
                      directed_rows[r].typed, directed_rows[r].res);

        while (words_sent < 80) send_set($urandom_range(1, 8), $urandom_range(0, 2));

        // hold off until the store has drained completely
        in_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);

        send_set(SET_CAP, KEYS_RANDOM);
        send_set(SET_CAP + 2, KEYS_NARROW);

        idle_on = 1'b0;
        while (words_sent < 235) send_set($urandom_range(1, 8), $urandom_range(0, 2));
        in_if.valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $error("%0d result words never arrived", expected_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

endmodule
